// File: rtl/lmae_pkg.sv
package lmae_pkg;

  localparam int unsigned LUMA_W  = 24;
  localparam int unsigned PAIR_W  = 25;
  localparam int unsigned LOG_W   = 21;
  localparam int unsigned SUM_W   = 45;
  localparam int unsigned CNT_W   = 25;
  localparam int unsigned VALUE_W = 30;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned SIZE_W  = 13;

  localparam logic [15:0] COEF_R = 16'd13933;
  localparam logic [15:0] COEF_G = 16'd46871;
  localparam logic [15:0] COEF_B = 16'd4732;

  localparam logic [VALUE_W-1:0] EXPO_ONE = 30'd65536;
  localparam logic [VALUE_W-1:0] EXPO_MIN = 30'd66;
  localparam logic [VALUE_W-1:0] EXPO_MAX = 30'd655360000;
  localparam logic [27:0]        K018_Q30 = 28'd193273528;

  typedef enum logic [1:0] {
    KIND_LUMA = 2'd0,
    KIND_MIP  = 2'd1,
    KIND_EXPO = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_ENABLE = 2'd2
  } reg_e;

  typedef struct packed {
    logic                    start;
    logic                    enable;
    logic signed [SUM_W-1:0] log_sum;
    logic [CNT_W-1:0]        log_count;
  } expo_req_t;

  function automatic logic [30:0] exp2_frac(input logic [3:0] k);
    logic [30:0] t;
    unique case (k)
      4'd0:  t = 31'd1518500250;
      4'd1:  t = 31'd1276901417;
      4'd2:  t = 31'd1170923762;
      4'd3:  t = 31'd1121280436;
      4'd4:  t = 31'd1097253708;
      4'd5:  t = 31'd1085434106;
      4'd6:  t = 31'd1079572136;
      4'd7:  t = 31'd1076653033;
      4'd8:  t = 31'd1075196443;
      4'd9:  t = 31'd1074468888;
      4'd10: t = 31'd1074105294;
      4'd11: t = 31'd1073923544;
      4'd12: t = 31'd1073832680;
      4'd13: t = 31'd1073787251;
      4'd14: t = 31'd1073764537;
      default: t = 31'd1073753181;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/lmae_line_mem.sv
module lmae_line_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [AW-1:0]                   waddr_i,
  input  logic [lmae_pkg::PAIR_W-1:0]     wdata_i,
  input  logic                            re_i,
  input  logic [AW-1:0]                   raddr_i,
  output logic [lmae_pkg::PAIR_W-1:0]     rdata_o
);

  logic [lmae_pkg::PAIR_W-1:0] mem [DEPTH];
  logic [lmae_pkg::PAIR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lmae_log2.sv
module lmae_log2 (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [lmae_pkg::LUMA_W-1:0]         luma_i,
  output logic                                done_o,
  output logic signed [lmae_pkg::LOG_W-1:0]   value_o
);

  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_SQ
  } lstate_e;

  lstate_e     state_q;
  logic [23:0] m_q;
  logic [4:0]  shift_q;
  logic [3:0]  step_q;
  logic [15:0] frac_q;
  logic        done_q;
  logic [47:0] sq;
  logic [24:0] sq_top;
  logic [4:0]  ipart;

  assign sq     = m_q * m_q;
  assign sq_top = sq[47:23];
  assign ipart  = 5'd11 - shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      m_q     <= '0;
      shift_q <= '0;
      step_q  <= '0;
      frac_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        L_IDLE: begin
          if (start_i) begin
            m_q     <= luma_i;
            shift_q <= '0;
            step_q  <= '0;
            frac_q  <= '0;
            state_q <= L_NORM;
          end
        end
        L_NORM: begin
          if (m_q[23]) begin
            state_q <= L_SQ;
          end else begin
            m_q     <= {m_q[22:0], 1'b0};
            shift_q <= shift_q + 5'd1;
          end
        end
        L_SQ: begin
          frac_q <= {frac_q[14:0], sq_top[24]};
          m_q    <= sq_top[24] ? sq_top[24:1] : sq_top[23:0];
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            done_q  <= 1'b1;
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign value_o = $signed({ipart, frac_q});

endmodule

// File: rtl/lmae_expo.sv
module lmae_expo (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lmae_pkg::expo_req_t                req_i,
  output logic                               done_o,
  output logic [lmae_pkg::VALUE_W-1:0]       value_o
);

  typedef enum logic [2:0] {
    E_IDLE,
    E_DIV,
    E_FIX,
    E_EXP,
    E_MUL,
    E_RND,
    E_CLAMP
  } estate_e;

  estate_e                        state_q;
  logic [lmae_pkg::SUM_W-1:0]     a_q;
  logic [lmae_pkg::CNT_W-1:0]     cnt_q;
  logic [lmae_pkg::CNT_W:0]       rem_q;
  logic                           neg_q;
  logic [5:0]                     bit_q;
  logic signed [5:0]              ip_q;
  logic [15:0]                    fp_q;
  logic [3:0]                     k_q;
  logic [31:0]                    acc_q;
  logic [63:0]                    prod_q;
  logic [35:0]                    v_q;
  logic                           done_q;
  logic [lmae_pkg::VALUE_W-1:0]   value_q;

  logic [lmae_pkg::CNT_W:0]       rem_sh;
  logic                           fits;
  logic signed [46:0]             e;
  logic [62:0]                    mac;
  logic [32:0]                    mac_sh;
  logic [5:0]                     s;
  logic [63:0]                    rnd;

  assign rem_sh = {rem_q[lmae_pkg::CNT_W-1:0], a_q[lmae_pkg::SUM_W-1]};
  assign fits   = rem_sh >= {1'b0, cnt_q};
  assign e      = neg_q ? $signed({2'b00, a_q}) + 47'sd1 * (rem_q != '0)
                        : -$signed({2'b00, a_q});
  assign mac    = acc_q * lmae_pkg::exp2_frac(k_q) + 63'(32'd1 << 29);
  assign mac_sh = mac[62:30];
  assign s      = 6'(7'sd44 - 7'(ip_q));
  assign rnd    = (prod_q + (64'd1 << (s - 6'd1))) >> s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      done_q  <= 1'b0;
      value_q <= '0;
      a_q     <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      neg_q   <= 1'b0;
      bit_q   <= '0;
      ip_q    <= '0;
      fp_q    <= '0;
      k_q     <= '0;
      acc_q   <= '0;
      prod_q  <= '0;
      v_q     <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        E_IDLE: begin
          if (req_i.start) begin
            if (!req_i.enable || req_i.log_count == '0) begin
              value_q <= lmae_pkg::EXPO_ONE;
              done_q  <= 1'b1;
            end else begin
              neg_q   <= req_i.log_sum[lmae_pkg::SUM_W-1];
              a_q     <= req_i.log_sum[lmae_pkg::SUM_W-1] ? 45'(-req_i.log_sum)
                                                          : 45'(req_i.log_sum);
              cnt_q   <= req_i.log_count;
              rem_q   <= '0;
              bit_q   <= '0;
              state_q <= E_DIV;
            end
          end
        end
        E_DIV: begin
          rem_q  <= fits ? rem_sh - {1'b0, cnt_q} : rem_sh;
          a_q    <= {a_q[lmae_pkg::SUM_W-2:0], fits};
          bit_q  <= bit_q + 6'd1;
          if (bit_q == 6'(lmae_pkg::SUM_W - 1)) begin
            state_q <= E_FIX;
          end
        end
        E_FIX: begin
          if (e >= 47'sd1376256) begin
            value_q <= lmae_pkg::EXPO_MAX;
            done_q  <= 1'b1;
            state_q <= E_IDLE;
          end else if (e < -47'sd1245184) begin
            value_q <= lmae_pkg::EXPO_MIN;
            done_q  <= 1'b1;
            state_q <= E_IDLE;
          end else begin
            ip_q    <= $signed(e[21:16]);
            fp_q    <= e[15:0];
            k_q     <= '0;
            acc_q   <= 32'd1 << 30;
            state_q <= E_EXP;
          end
        end
        E_EXP: begin
          if (fp_q[15]) begin
            acc_q <= mac_sh[31:0];
          end
          fp_q <= {fp_q[14:0], 1'b0};
          k_q  <= k_q + 4'd1;
          if (k_q == 4'd15) begin
            state_q <= E_MUL;
          end
        end
        E_MUL: begin
          prod_q  <= acc_q * lmae_pkg::K018_Q30;
          state_q <= E_RND;
        end
        E_RND: begin
          v_q     <= rnd[35:0];
          state_q <= E_CLAMP;
        end
        E_CLAMP: begin
          if (v_q < 36'(lmae_pkg::EXPO_MIN)) begin
            value_q <= lmae_pkg::EXPO_MIN;
          end else if (v_q > 36'(lmae_pkg::EXPO_MAX)) begin
            value_q <= lmae_pkg::EXPO_MAX;
          end else begin
            value_q <= v_q[lmae_pkg::VALUE_W-1:0];
          end
          done_q  <= 1'b1;
          state_q <= E_IDLE;
        end
        default: state_q <= E_IDLE;
      endcase
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

// File: rtl/luma_mip_and_auto_exposure_unit.sv
// Luma, half-size box mip and log-average auto exposure over a raster pixel
// stream. Each pixel gives a luma transaction, a mip transaction when it
// completes a 2x2 block, and the last pixel of a frame adds the exposure
// transaction with tlast set. One pixel at a time is processed. A pixel with
// zero luma skips the log2 unit; otherwise the log2 unit runs up to 23
// normalizing shifts and a check, then 16 squaring steps on one 24x24
// multiplier. The last pixel of a frame also starts the exposure unit,
// which, when enabled and given a nonzero log count, runs 45 divider steps,
// a range check that may clamp at once, 16 exp2 steps and a multiply, round
// and clamp tail. Horizontal pair sums of even rows live in a line memory of
// (MAX_WIDTH+1)/2 entries with a registered read; it needs no clearing after
// reset. The next pixel is taken while the last result still waits in the
// output register.
module luma_mip_and_auto_exposure_unit #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // red [23:0], green [47:24], blue [71:48]
  input  logic [71:0] s_axis_tdata,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // value [29:0], pos_x [41:30], pos_y [53:42], zero [55:54]
  output logic [55:0] m_axis_tdata,
  // kind [1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [12:0] cfg_data_i
);

  localparam int unsigned XW         = $clog2(MAX_WIDTH);
  localparam int unsigned YW         = $clog2(MAX_HEIGHT);
  localparam int unsigned WW         = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW         = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int unsigned LAW        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_LUMA_OUT,
    S_MIP_OUT,
    S_LOG,
    S_LOG_WAIT,
    S_POS,
    S_EXP_WAIT,
    S_EXP_OUT
  } state_e;

  state_e state_q;

  logic [lmae_pkg::SIZE_W-1:0] width_q, height_q;
  logic                        enable_q;

  logic [XW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [lmae_pkg::LUMA_W-1:0] left_q, lum_q;
  logic [lmae_pkg::PAIR_W-1:0] pair_q;
  logic [37:0] pr_q, pb_q;
  logic [39:0] pg_q;
  logic        mip_q, mip_rd_q, last_col_q, last_row_q;
  logic signed [lmae_pkg::SUM_W-1:0] log_sum_q;
  logic [lmae_pkg::CNT_W-1:0]        log_cnt_q;
  logic [lmae_pkg::VALUE_W-1:0]      expo_q;

  logic        m_valid_q, m_last_q;
  logic [55:0] m_data_q;
  logic [1:0]  m_user_q;

  logic [WW-1:0] w_eff, wm1;
  logic [HW-1:0] h_eff, hm1;
  logic          last_col, last_row;
  logic [39:0]   luma_sum;
  logic [lmae_pkg::LUMA_W-1:0] lum;
  logic          pair_done;
  logic [lmae_pkg::PAIR_W-1:0] pair;
  logic          mem_we, mem_re;
  logic [LAW-1:0] mem_addr;
  logic [lmae_pkg::PAIR_W-1:0] mem_rdata;
  logic [lmae_pkg::PAIR_W:0]   mip_sum;
  logic [lmae_pkg::LUMA_W-1:0] mip_val;
  logic          out_free, out_load;
  logic          log_start, log_done;
  logic signed [lmae_pkg::LOG_W-1:0] log_val;
  lmae_pkg::expo_req_t expo_req;
  logic          expo_done;
  logic [lmae_pkg::VALUE_W-1:0] expo_val;

  always_comb begin
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (14'(width_q) > 14'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (14'(height_q) > 14'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  assign wm1      = w_eff - WW'(1);
  assign hm1      = h_eff - HW'(1);
  assign last_col = WW'(x_q) >= wm1;
  assign last_row = HW'(y_q) >= hm1;

  assign luma_sum  = 40'(pr_q) + pg_q + 40'(pb_q);
  assign lum       = luma_sum[39:16];
  assign pair_done = x_q[0] || last_col;
  assign pair      = x_q[0] ? 25'(left_q) + 25'(lum) : {lum, 1'b0};

  assign mem_addr = LAW'(x_q >> 1);
  assign mem_re   = (state_q == S_SUM) && pair_done && y_q[0];
  assign mem_we   = (state_q == S_SUM) && pair_done && !y_q[0] && !last_row;

  lmae_line_mem #(
    .DEPTH (LINE_DEPTH),
    .AW    (LAW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (pair),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  assign mip_sum = 26'(mem_rdata) + 26'(pair_q);
  assign mip_val = mip_rd_q ? mip_sum[25:2] : pair_q[24:1];

  assign log_start = (state_q == S_LOG) && (lum_q != '0);

  lmae_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .luma_i  (lum_q),
    .done_o  (log_done),
    .value_o (log_val)
  );

  assign expo_req.start     = (state_q == S_POS) && last_col_q && last_row_q;
  assign expo_req.enable    = enable_q;
  assign expo_req.log_sum   = log_sum_q;
  assign expo_req.log_count = log_cnt_q;

  lmae_expo u_expo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (expo_req),
    .done_o  (expo_done),
    .value_o (expo_val)
  );

  assign out_free      = !m_valid_q || m_axis_tready;
  assign out_load      = out_free && ((state_q == S_LUMA_OUT) || (state_q == S_MIP_OUT) ||
                                      (state_q == S_EXP_OUT));
  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1920;
      height_q <= 13'd1080;
      enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lmae_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        lmae_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        lmae_pkg::REG_ENABLE: enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      x_q        <= '0;
      y_q        <= '0;
      left_q     <= '0;
      log_sum_q  <= '0;
      log_cnt_q  <= '0;
      m_valid_q  <= 1'b0;
      m_last_q   <= 1'b0;
      m_user_q   <= lmae_pkg::KIND_LUMA;
      m_data_q   <= '0;
      lum_q      <= '0;
      pair_q     <= '0;
      pr_q       <= '0;
      pg_q       <= '0;
      pb_q       <= '0;
      mip_q      <= 1'b0;
      mip_rd_q   <= 1'b0;
      last_col_q <= 1'b0;
      last_row_q <= 1'b0;
      expo_q     <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && !out_load) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            pr_q    <= s_axis_tdata[23:0] * lmae_pkg::COEF_R[13:0];
            pg_q    <= s_axis_tdata[47:24] * lmae_pkg::COEF_G;
            pb_q    <= s_axis_tdata[71:48] * lmae_pkg::COEF_B[13:0];
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          lum_q      <= lum;
          pair_q     <= pair;
          mip_q      <= pair_done && (y_q[0] || last_row);
          mip_rd_q   <= y_q[0];
          last_col_q <= last_col;
          last_row_q <= last_row;
          if (!pair_done) begin
            left_q <= lum;
          end
          state_q <= S_LUMA_OUT;
        end
        S_LUMA_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_last_q  <= 1'b0;
            m_user_q  <= lmae_pkg::KIND_LUMA;
            m_data_q  <= {2'b00, 12'(y_q), 12'(x_q), 30'(lum_q)};
            state_q   <= mip_q ? S_MIP_OUT : S_LOG;
          end
        end
        S_MIP_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_last_q  <= 1'b0;
            m_user_q  <= lmae_pkg::KIND_MIP;
            m_data_q  <= {2'b00, 12'(y_q >> 1), 12'(x_q >> 1), 30'(mip_val)};
            state_q   <= S_LOG;
          end
        end
        S_LOG: begin
          state_q <= (lum_q != '0) ? S_LOG_WAIT : S_POS;
        end
        S_LOG_WAIT: begin
          if (log_done) begin
            log_sum_q <= log_sum_q + 45'(log_val);
            log_cnt_q <= log_cnt_q + 25'd1;
            state_q   <= S_POS;
          end
        end
        S_POS: begin
          if (last_col_q) begin
            x_q <= '0;
            if (last_row_q) begin
              y_q     <= '0;
              state_q <= S_EXP_WAIT;
            end else begin
              y_q     <= y_q + YW'(1);
              state_q <= S_IDLE;
            end
          end else begin
            x_q     <= x_q + XW'(1);
            state_q <= S_IDLE;
          end
        end
        S_EXP_WAIT: begin
          if (expo_done) begin
            expo_q  <= expo_val;
            state_q <= S_EXP_OUT;
          end
        end
        S_EXP_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_last_q  <= 1'b1;
            m_user_q  <= lmae_pkg::KIND_EXPO;
            m_data_q  <= {26'd0, expo_q};
            log_sum_q <= '0;
            log_cnt_q <= '0;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// File: dv/testbench.sv
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_ENTRIES = 2048;
  localparam int unsigned STALL_LIMIT  = 20000;

  typedef struct packed {
    lmae_pkg::kind_e                       kind;
    logic [lmae_pkg::VALUE_W-1:0] value;
    logic [lmae_pkg::POS_W-1:0]   pos_x;
    logic [lmae_pkg::POS_W-1:0]   pos_y;
    logic                         last;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [12:0] cfg_data_i = '0;

  luma_mip_and_auto_exposure_unit dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic [12:0] frame_w = 13'd1920, frame_h = 13'd1080;
  logic        expo_on = 1'b1;
  int unsigned col_pos, row_pos, left_val;
  int unsigned pair_line [LINE_ENTRIES];
  logic        line_written [LINE_ENTRIES];
  longint      log_acc;
  int unsigned log_pixels;

  result_t     expected_results[$];
  int          error_count;
  int          pixels_sent, results_seen, frames_seen;
  int          idle_cycles;
  int          stall_mode;

  function automatic longint log2_fixed(input int unsigned lum);
    int          msb;
    longint unsigned mant;
    longint      frac;
    msb = 0;
    for (int i = 0; i < 32; i++) if (lum >> i) msb = i;
    mant = longint'(lum) << (23 - msb);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      mant = (mant * mant) >> 23;
      frac = frac << 1;
      if (mant >= (64'd1 << 24)) begin
        frac = frac | 1;
        mant = mant >> 1;
      end
    end
    return longint'(msb - 12) * 65536 + frac;
  endfunction

  function automatic longint floor_div(input longint a, input longint b);
    if (a >= 0) return a / b;
    return -((-a + b - 1) / b);
  endfunction

  function automatic logic [lmae_pkg::VALUE_W-1:0] exposure_value();
    longint mean, e, ip, fp;
    longint unsigned acc, prod, v;
    int s;
    if (!expo_on || log_pixels == 0) return lmae_pkg::EXPO_ONE;
    mean = floor_div(log_acc, longint'(log_pixels));
    e = -mean;
    ip = floor_div(e, 65536);
    fp = e - ip * 65536;
    if (ip > 20) return lmae_pkg::EXPO_MAX;
    if (ip < -19) return lmae_pkg::EXPO_MIN;
    acc = 64'd1 << 30;
    for (int k = 0; k < 16; k++)
      if ((fp >> (15 - k)) & 1)
        acc = (acc * longint'(lmae_pkg::exp2_frac(4'(k))) + (64'd1 << 29)) >> 30;
    prod = acc * longint'(lmae_pkg::K018_Q30);
    s = 44 - int'(ip);
    v = (prod + (64'd1 << (s - 1))) >> s;
    if (v < lmae_pkg::EXPO_MIN) return lmae_pkg::EXPO_MIN;
    if (v > lmae_pkg::EXPO_MAX) return lmae_pkg::EXPO_MAX;
    return v[lmae_pkg::VALUE_W-1:0];
  endfunction

  function automatic void push_result(lmae_pkg::kind_e k, int unsigned v, int unsigned px,
                                      int unsigned py, logic l);
    result_t r;
    r.kind = k;
    r.value = v[lmae_pkg::VALUE_W-1:0];
    r.pos_x = px[lmae_pkg::POS_W-1:0];
    r.pos_y = py[lmae_pkg::POS_W-1:0];
    r.last = l;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_pixel(input logic [23:0] r, g, b);
    int unsigned lum, w, h, x, y, pair, mx, above;
    logic done;
    lum = int'((longint'(r) * 13933 + longint'(g) * 46871 + longint'(b) * 4732) >> 16);
    w = frame_w;
    h = frame_h;
    if (w < 1) w = 1;
    if (w > 4096) w = 4096;
    if (h < 1) h = 1;
    if (h > 4096) h = 4096;
    x = col_pos;
    y = row_pos;
    done = 1'b0;
    pair = 0;
    push_result(lmae_pkg::KIND_LUMA, lum, x, y, 1'b0);
    if (x & 1) begin
      pair = left_val + lum;
      done = 1'b1;
    end else if (x >= w - 1) begin
      pair = 2 * lum;
      done = 1'b1;
    end else begin
      left_val = lum;
    end
    if (done) begin
      mx = x >> 1;
      if (y & 1) begin
        above = (mx < LINE_ENTRIES) ? pair_line[mx] : 0;
        if (mx < LINE_ENTRIES && !line_written[mx])
          $error("stimulus reads an unwritten line entry at %0d", mx);
        push_result(lmae_pkg::KIND_MIP, (above + pair) >> 2, mx, y >> 1, 1'b0);
      end else if (y >= h - 1) begin
        push_result(lmae_pkg::KIND_MIP, (2 * pair) >> 2, mx, y >> 1, 1'b0);
      end else if (mx < LINE_ENTRIES) begin
        pair_line[mx] = pair;
        line_written[mx] = 1'b1;
      end
    end
    if (lum != 0) begin
      log_acc += log2_fixed(lum);
      log_pixels++;
    end
    if (x >= w - 1) begin
      col_pos = 0;
      if (y >= h - 1) begin
        row_pos = 0;
        push_result(lmae_pkg::KIND_EXPO, exposure_value(), 0, 0, 1'b1);
        log_acc = 0;
        log_pixels = 0;
      end else begin
        row_pos = y + 1;
      end
    end else begin
      col_pos = x + 1;
    end
  endfunction

  // hold tvalid after the transaction; a gap or a drain drops it
  task automatic send_pixel(input logic [23:0] r, g, b);
    s_axis_tdata <= {b, g, r};
    s_axis_tvalid <= 1'b1;
    predict_pixel(r, g, b);
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic input_gap(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic send_random_pixel(input int unsigned style);
    logic [23:0] r, g, b;
    case (style)
      0: begin
        r = $urandom;
        g = $urandom;
        b = $urandom;
      end
      1: begin
        r = $urandom_range(0, 8191);
        g = $urandom_range(0, 8191);
        b = $urandom_range(0, 8191);
      end
      default: begin
        r = ($urandom_range(0, 3) == 0) ? '0 : 24'($urandom_range(1, 15));
        g = ($urandom_range(0, 3) == 0) ? '0 : 24'($urandom_range(0, 3));
        b = '0;
      end
    endcase
    send_pixel(r, g, b);
    if ($urandom_range(0, 3) == 0) input_gap($urandom_range(1, 4));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_reg(input lmae_pkg::reg_e idx, input logic [12:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lmae_pkg::REG_WIDTH:  frame_w = val;
      lmae_pkg::REG_HEIGHT: frame_h = val;
      default:              expo_on = val[0];
    endcase
  endtask

  task automatic set_frame(input logic [12:0] w, h, input logic en);
    drain();
    write_reg(lmae_pkg::REG_WIDTH, w);
    write_reg(lmae_pkg::REG_HEIGHT, h);
    write_reg(lmae_pkg::REG_ENABLE, {12'd0, en});
  endtask

  task automatic run_frames(input int unsigned frames, input int unsigned style);
    int unsigned w, h;
    w = frame_w;
    h = frame_h;
    repeat (frames * w * h) send_random_pixel(style);
  endtask

  task automatic test_channel_extremes();
    set_frame(13'd2, 13'd2, 1'b1);
    send_pixel('1, '1, '1);
    send_pixel('0, '0, '0);
    send_pixel(24'hFFFFFF, '0, '0);
    send_pixel('0, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel('0, '0, '0);
    send_pixel('0, '0, '0);
    send_pixel('0, '0, 24'd1);
    send_pixel(24'd4096, 24'd4096, 24'd4096);
  endtask

  task automatic test_exposure_clamps();
    set_frame(13'd1, 13'd1, 1'b1);
    send_pixel('1, '1, '1);
    send_pixel('0, 24'd2, '0);
    set_frame(13'd1, 13'd1, 1'b0);
    send_pixel(24'd4096, 24'd4096, 24'd4096);
  endtask

  task automatic test_odd_edges();
    set_frame(13'd3, 13'd3, 1'b1);
    for (int i = 0; i < 9; i++) send_pixel(24'(i * 40000), 24'(i * 9000), 24'(i * 777));
  endtask

  task automatic test_size_clamp_and_midframe();
    set_frame(13'd0, 13'd0, 1'b1);
    send_pixel(24'd5000, 24'd6000, 24'd7000);
    set_frame(13'd4, 13'd2, 1'b1);
    repeat (2) send_random_pixel(0);
    drain();
    write_reg(lmae_pkg::REG_WIDTH, 13'd2);
    repeat (6) send_random_pixel(0);
    set_frame(13'd8191, 13'd1, 1'b1);
    send_random_pixel(1);
    set_frame(13'd4096, 13'd1, 1'b1);
    send_random_pixel(0);
    set_frame(13'd1, 13'd1, 1'b1);
    send_random_pixel(0);
  endtask

  task automatic test_random_frames();
    set_frame(13'd4, 13'd4, 1'b1);
    run_frames(4, 0);
    set_frame(13'd5, 13'd3, 1'b1);
    run_frames(3, 1);
    set_frame(13'd3, 13'd6, 1'b0);
    run_frames(2, 0);
    set_frame(13'd7, 13'd5, 1'b1);
    run_frames(2, 2);
    set_frame(13'd2, 13'd1, 1'b1);
    run_frames(6, 2);
    set_frame(13'd1, 13'd4, 1'b1);
    run_frames(4, 0);
  endtask

  always @(posedge clk_i) begin
    result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.kind = lmae_pkg::kind_e'(m_axis_tuser);
      got.value = m_axis_tdata[29:0];
      got.pos_x = m_axis_tdata[41:30];
      got.pos_y = m_axis_tdata[53:42];
      got.last = m_axis_tlast;
      results_seen++;
      if (got.kind == lmae_pkg::KIND_EXPO) frames_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected transaction kind %0d value %0d", got.kind, got.value);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind) begin
          $error("kind expected %0d actual %0d", want.kind, got.kind);
          error_count++;
        end
        if (got.value !== want.value) begin
          $error("value expected %0d actual %0d", want.value, got.value);
          error_count++;
        end
        if (got.pos_x !== want.pos_x) begin
          $error("pos_x expected %0d actual %0d", want.pos_x, got.pos_x);
          error_count++;
        end
        if (got.pos_y !== want.pos_y) begin
          $error("pos_y expected %0d actual %0d", want.pos_y, got.pos_y);
          error_count++;
        end
        if (got.last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, got.last);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ~m_axis_tready;
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    stall_mode = 0;
    col_pos = 0;
    row_pos = 0;
    left_val = 0;
    log_acc = 0;
    log_pixels = 0;
    foreach (line_written[i]) line_written[i] = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_channel_extremes();
    test_exposure_clamps();
    test_odd_edges();
    test_size_clamp_and_midframe();
    test_random_frames();
    drain();
    $display("Covered %0d pixels, %0d output transactions, %0d frame exposures.",
             pixels_sent, results_seen, frames_seen);
    if (error_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
